// ===== hw/rtl/wcsp_pkg.sv =====
// ----------------------------------------------------------------------------
// WCNF clause stream parser package
// Shared widths, record kinds, character codes and character classes.
// ----------------------------------------------------------------------------
`default_nettype none

package wcsp_pkg;

  localparam int DefMaxVars = 16777216;
  localparam int DefNumBits = 64;

  localparam int ByteW    = 8;
  localparam int KindW    = 3;
  localparam int WeightW  = 64;
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  localparam logic [ApbAddrW-3:0] RegIdxSatMode = 1'b0;

  typedef enum logic [KindW-1:0] {
    KIND_LIT        = 3'd0,
    KIND_CLAUSE_END = 3'd1,
    KIND_TOP        = 3'd2,
    KIND_EOI        = 3'd3,
    KIND_ERROR      = 3'd4
  } kind_e;

  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChLf    = 8'h0a;
  localparam logic [ByteW-1:0] ChCr    = 8'h0d;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChPlus  = 8'h2b;
  localparam logic [ByteW-1:0] ChMinus = 8'h2d;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;
  localparam logic [ByteW-1:0] ChC     = 8'h63;
  localparam logic [ByteW-1:0] ChP     = 8'h70;
  localparam logic [ByteW-1:0] ChW     = 8'h77;

  function automatic logic is_ws(logic [ByteW-1:0] ch);
    return ch inside {[ChTab:ChCr], ChSpace};
  endfunction

  function automatic logic is_digit(logic [ByteW-1:0] ch);
    return ch inside {[ChZero:ChNine]};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wcnf_clause_stream_parser_top.sv =====
// ----------------------------------------------------------------------------
// WCNF clause stream parser
// Parses DIMACS CNF/WCNF bytes into lit, clause-end, top, EOI, error records.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one character per word in tdata; tuser high marks end of
//   input (tdata ignored). m_axis carries one record per word: tuser is the
//   record kind, tdata the record fields, tlast marks the final record caused
//   by one input word. The APB port holds sat_mode at offset 0x0.
//   Throughput: one input word per cycle while s_axis_tready is high. A word
//   makes zero, one or two records; a record can leave in the cycle after its
//   input word is taken at the earliest, and m_axis moves one record per cycle
//   while m_axis_tready is high, so the two records of a word leave in turn.
//   A four-record output queue decouples the sides: s_axis_tready stays high
//   while at most two records wait, so a stalled receiver blocks input only
//   once three records are queued.
//   Reset empties the queue, clears sat_mode and puts the parser at a line
//   start with no header seen and no top value. A parse error is sticky until
//   reset: later characters make no records, each end of input makes one
//   error record.
// ----------------------------------------------------------------------------
`default_nettype none

module wcnf_clause_stream_parser_top #(
  parameter int MAX_VARS = wcsp_pkg::DefMaxVars,
  parameter int NUM_BITS = wcsp_pkg::DefNumBits,
  localparam int VarW  = $clog2(MAX_VARS),
  localparam int CntW  = $clog2(MAX_VARS + 1),
  localparam int PayW  = VarW + 1 + wcsp_pkg::WeightW + 1 + 1 + CntW,
  localparam int DataW = ((PayW + 7) / 8) * 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // data_byte
  input  wire logic [wcsp_pkg::ByteW-1:0]    s_axis_tdata,
  // end_of_input
  input  wire logic                          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // var_index, negated, clause_weight, hard, unit_soft, var_count, zero pad
  output logic [DataW-1:0]                   m_axis_tdata,
  // record_kind
  output logic [wcsp_pkg::KindW-1:0]         m_axis_tuser,
  output logic                               m_axis_tlast,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [wcsp_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [wcsp_pkg::ApbDataW-1:0] pwdata,
  output logic [wcsp_pkg::ApbDataW-1:0]      prdata,
  output logic                               pready
);
  import wcsp_pkg::*;

  localparam int AccW   = NUM_BITS - 1;
  localparam int SatW   = AccW + 4;
  localparam int QDepth = 4;
  localparam int PtrW   = $clog2(QDepth);
  localparam logic [AccW-1:0] MaxVarsA = AccW'(MAX_VARS);

  typedef enum logic [9:0] {
    PH_IDLE      = 10'b00_0000_0001,
    PH_COMMENT   = 10'b00_0000_0010,
    PH_HDR_WS    = 10'b00_0000_0100,
    PH_HDR_SKIP  = 10'b00_0000_1000,
    PH_HDR_SCAN  = 10'b00_0001_0000,
    PH_HDR_LINE  = 10'b00_0010_0000,
    PH_TOP_DIG   = 10'b00_0100_0000,
    PH_NUM_START = 10'b00_1000_0000,
    PH_NUM_SIGN  = 10'b01_0000_0000,
    PH_NUM_DIG   = 10'b10_0000_0000
  } phase_e;

  typedef enum logic [1:0] {
    PUR_COUNT  = 2'd0,
    PUR_WEIGHT = 2'd1,
    PUR_LIT    = 2'd2
  } purpose_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [DataW-1:0] data;
  } rec_t;

  function automatic rec_t pack_rec(kind_e kind, logic [VarW-1:0] var_idx, logic neg,
                                    logic [WeightW-1:0] weight, logic hard, logic unit,
                                    logic [CntW-1:0] cnt);
    rec_t r;
    r.kind           = kind;
    r.data           = '0;
    r.data[PayW-1:0] = {cnt, unit, hard, weight, neg, var_idx};
    return r;
  endfunction

  // parser state
  phase_e             phase_q, phase_d;
  purpose_e           purpose_q, purpose_d;
  logic [AccW-1:0]    accum_q, accum_d;
  logic               neg_q, neg_d;
  logic [1:0]         skip_q, skip_d;
  logic               cnt_idx_q, cnt_idx_d;
  logic               weighted_q, weighted_d;
  logic [WeightW-1:0] top_q, top_d;
  logic [WeightW-1:0] weight_q, weight_d;
  logic [1:0]         tally_q, tally_d;
  logic [CntW-1:0]    vars_q, vars_d;
  logic               err_q, err_d;
  logic               sat_mode_q;

  // output queue
  rec_t               fifo_q [QDepth];
  logic               fifo_last_q [QDepth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]      count_q, count_d;

  logic               in_fire, out_fire, cfg_wr;
  logic [ByteW-1:0]   in_byte;
  logic               in_eoi, in_ws, in_dig, in_sign;
  logic [3:0]         in_digit;
  logic [SatW-1:0]    acc_mul;
  logic [AccW-1:0]    acc_next;
  logic [WeightW-1:0] acc_ext, num_val;
  logic               ce_top_hit, ce_hard, ce_unit;
  logic [WeightW-1:0] ce_weight;
  logic               redo_idle, redo_scan, redo_line, redo_num;
  rec_t               recs [2];
  logic [1:0]         n_rec;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign in_byte  = s_axis_tdata;
  assign in_eoi   = s_axis_tuser;
  assign in_ws    = is_ws(in_byte);
  assign in_dig   = is_digit(in_byte);
  assign in_sign  = (in_byte == ChMinus) || (in_byte == ChPlus);
  assign in_digit = in_byte[3:0];

  // saturating accumulate: a*10 + d, clamp to the largest magnitude
  assign acc_mul  = (SatW'(accum_q) << 3) + (SatW'(accum_q) << 1) + SatW'(in_digit);
  assign acc_next = (|acc_mul[SatW-1:AccW]) ? '1 : acc_mul[AccW-1:0];

  assign acc_ext  = WeightW'(accum_q);
  assign num_val  = neg_q ? -acc_ext : acc_ext;

  assign ce_top_hit = !top_q[WeightW-1] && ($signed(weight_q) >= $signed(top_q));
  assign ce_hard    = sat_mode_q || ce_top_hit;
  assign ce_weight  = (!sat_mode_q && ce_top_hit) ? top_q : weight_q;
  assign ce_unit    = !ce_hard && (tally_q == 2'd1);

  always_comb begin
    phase_d    = phase_q;
    purpose_d  = purpose_q;
    accum_d    = accum_q;
    neg_d      = neg_q;
    skip_d     = skip_q;
    cnt_idx_d  = cnt_idx_q;
    weighted_d = weighted_q;
    top_d      = top_q;
    weight_d   = weight_q;
    tally_d    = tally_q;
    vars_d     = vars_q;
    err_d      = err_q;
    redo_idle  = 1'b0;
    redo_scan  = 1'b0;
    redo_line  = 1'b0;
    redo_num   = 1'b0;
    n_rec      = 2'd0;
    recs[0]    = '0;
    recs[1]    = '0;
    if (in_fire) begin
      if (err_q) begin
        if (in_eoi) begin
          recs[0] = pack_rec(KIND_ERROR, '0, 1'b0, '0, 1'b0, 1'b0, vars_q);
          n_rec   = 2'd1;
        end
      end else begin
        case (phase_q)
          PH_NUM_DIG: begin
            if (!in_eoi && in_dig) begin
              accum_d = acc_next;
            end else begin
              case (purpose_q)
                PUR_COUNT: begin
                  if (!cnt_idx_q) begin
                    cnt_idx_d = 1'b1;
                    redo_num  = 1'b1;
                  end else begin
                    phase_d   = PH_HDR_SCAN;
                    redo_scan = 1'b1;
                  end
                end
                PUR_WEIGHT: begin
                  weight_d  = num_val;
                  purpose_d = PUR_LIT;
                  redo_num  = 1'b1;
                end
                default: begin
                  if (accum_q == '0) begin
                    recs[n_rec[0]] = pack_rec(KIND_CLAUSE_END, '0, 1'b0, ce_weight, ce_hard,
                                              ce_unit, vars_d);
                    n_rec     = n_rec + 2'd1;
                    weight_d  = WeightW'(1);
                    tally_d   = 2'd0;
                    accum_d   = '0;
                    neg_d     = 1'b0;
                    phase_d   = PH_IDLE;
                    redo_idle = 1'b1;
                  end else if (accum_q > MaxVarsA) begin
                    err_d          = 1'b1;
                    recs[n_rec[0]] = pack_rec(KIND_ERROR, '0, 1'b0, '0, 1'b0, 1'b0, vars_d);
                    n_rec          = n_rec + 2'd1;
                  end else begin
                    recs[n_rec[0]] = pack_rec(KIND_LIT, VarW'(accum_q - AccW'(1)), neg_q, '0,
                                              1'b0, 1'b0, vars_d);
                    n_rec = n_rec + 2'd1;
                    if (accum_q > AccW'(vars_q)) begin
                      vars_d = CntW'(accum_q);
                    end
                    if (tally_q != 2'd2) begin
                      tally_d = tally_q + 2'd1;
                    end
                    redo_num = 1'b1;
                  end
                end
              endcase
            end
          end
          PH_NUM_START: begin
            redo_num = 1'b1;
          end
          PH_NUM_SIGN: begin
            if (!in_eoi && in_dig) begin
              accum_d = AccW'(in_digit);
              phase_d = PH_NUM_DIG;
            end else begin
              err_d          = 1'b1;
              recs[n_rec[0]] = pack_rec(KIND_ERROR, '0, 1'b0, '0, 1'b0, 1'b0, vars_d);
              n_rec          = n_rec + 2'd1;
            end
          end
          PH_IDLE: begin
            redo_idle = 1'b1;
          end
          PH_COMMENT, PH_HDR_LINE: begin
            redo_line = 1'b1;
          end
          PH_HDR_WS: begin
            if (in_eoi) begin
              err_d          = 1'b1;
              recs[n_rec[0]] = pack_rec(KIND_ERROR, '0, 1'b0, '0, 1'b0, 1'b0, vars_d);
              n_rec          = n_rec + 2'd1;
            end else if (!in_ws) begin
              if (in_byte == ChW) begin
                weighted_d = 1'b1;
              end
              skip_d  = ((in_byte == ChW) || weighted_q) ? 2'd3 : 2'd2;
              phase_d = PH_HDR_SKIP;
            end
          end
          PH_HDR_SKIP: begin
            if (in_eoi) begin
              err_d          = 1'b1;
              recs[n_rec[0]] = pack_rec(KIND_ERROR, '0, 1'b0, '0, 1'b0, 1'b0, vars_d);
              n_rec          = n_rec + 2'd1;
            end else if (skip_q <= 2'd1) begin
              skip_d    = 2'd0;
              purpose_d = PUR_COUNT;
              neg_d     = 1'b0;
              accum_d   = '0;
              phase_d   = PH_NUM_START;
            end else begin
              skip_d = skip_q - 2'd1;
            end
          end
          PH_HDR_SCAN: begin
            redo_scan = 1'b1;
          end
          PH_TOP_DIG: begin
            if (!in_eoi && in_dig) begin
              accum_d = acc_next;
            end else begin
              top_d          = acc_ext;
              recs[n_rec[0]] = pack_rec(KIND_TOP, '0, 1'b0, top_d, 1'b0, 1'b0, vars_d);
              n_rec          = n_rec + 2'd1;
              phase_d        = PH_HDR_LINE;
              redo_line      = 1'b1;
            end
          end
          default: ;
        endcase

        if (redo_scan) begin
          if (in_eoi || (in_byte == ChLf)) begin
            if (!top_d[WeightW-1]) begin
              recs[n_rec[0]] = pack_rec(KIND_TOP, '0, 1'b0, top_d, 1'b0, 1'b0, vars_d);
              n_rec          = n_rec + 2'd1;
            end
            phase_d   = PH_IDLE;
            redo_idle = in_eoi;
          end else if (in_dig) begin
            accum_d = AccW'(in_digit);
            phase_d = PH_TOP_DIG;
          end
        end

        if (redo_line) begin
          if (in_eoi) begin
            phase_d   = PH_IDLE;
            redo_idle = 1'b1;
          end else if (in_byte == ChLf) begin
            phase_d = PH_IDLE;
          end
        end

        if (redo_idle) begin
          if (in_eoi) begin
            recs[n_rec[0]] = pack_rec(KIND_EOI, '0, 1'b0, '0, 1'b0, 1'b0, vars_d);
            n_rec          = n_rec + 2'd1;
            weight_d       = WeightW'(1);
            tally_d        = 2'd0;
            accum_d        = '0;
            neg_d          = 1'b0;
          end else if (in_ws) begin
            phase_d = PH_IDLE;
          end else if (in_byte == ChC) begin
            phase_d = PH_COMMENT;
          end else if (in_byte == ChP) begin
            phase_d   = PH_HDR_WS;
            cnt_idx_d = 1'b0;
          end else begin
            weight_d  = WeightW'(1);
            tally_d   = 2'd0;
            purpose_d = weighted_q ? PUR_WEIGHT : PUR_LIT;
            redo_num  = 1'b1;
          end
        end

        if (redo_num) begin
          neg_d   = 1'b0;
          accum_d = '0;
          phase_d = PH_NUM_START;
          if (in_eoi || (!in_ws && !in_sign && !in_dig)) begin
            err_d          = 1'b1;
            recs[n_rec[0]] = pack_rec(KIND_ERROR, '0, 1'b0, '0, 1'b0, 1'b0, vars_d);
            n_rec          = n_rec + 2'd1;
          end else if (in_sign) begin
            neg_d   = (in_byte == ChMinus);
            phase_d = PH_NUM_SIGN;
          end else if (in_dig) begin
            accum_d = AccW'(in_digit);
            phase_d = PH_NUM_DIG;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      purpose_q  <= PUR_LIT;
      accum_q    <= '0;
      neg_q      <= 1'b0;
      skip_q     <= 2'd0;
      cnt_idx_q  <= 1'b0;
      weighted_q <= 1'b0;
      top_q      <= '1;
      weight_q   <= WeightW'(1);
      tally_q    <= 2'd0;
      vars_q     <= '0;
      err_q      <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      purpose_q  <= purpose_d;
      accum_q    <= accum_d;
      neg_q      <= neg_d;
      skip_q     <= skip_d;
      cnt_idx_q  <= cnt_idx_d;
      weighted_q <= weighted_d;
      top_q      <= top_d;
      weight_q   <= weight_d;
      tally_q    <= tally_d;
      vars_q     <= vars_d;
      err_q      <= err_d;
    end
  end

  // configuration
  assign cfg_wr = psel && penable && pwrite && (paddr[ApbAddrW-1:2] == RegIdxSatMode);
  assign pready = 1'b1;
  assign prdata = (paddr[ApbAddrW-1:2] == RegIdxSatMode) ? ApbDataW'(sat_mode_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      sat_mode_q <= pwdata[0];
    end
  end

  // output queue
  assign count_d       = count_q + (PtrW + 1)'(n_rec) - (PtrW + 1)'(out_fire);
  assign s_axis_tready = (count_q <= (PtrW + 1)'(QDepth - 2));
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tuser  = fifo_q[rd_ptr_q].kind;
  assign m_axis_tdata  = fifo_q[rd_ptr_q].data;
  assign m_axis_tlast  = fifo_last_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n_rec);
      rd_ptr_q <= rd_ptr_q + PtrW'(out_fire);
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_rec != 2'd0) begin
      fifo_q[wr_ptr_q]      <= recs[0];
      fifo_last_q[wr_ptr_q] <= (n_rec == 2'd1);
    end
    if (n_rec == 2'd2) begin
      fifo_q[wr_ptr_q + PtrW'(1)]      <= recs[1];
      fifo_last_q[wr_ptr_q + PtrW'(1)] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wcsp_port_checker.sv =====
// ----------------------------------------------------------------------------
// WCNF clause stream parser port checker
// Port-level checks on the record stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wcsp_port_checker #(
  parameter int MAX_VARS = wcsp_pkg::DefMaxVars,
  localparam int VarW  = $clog2(MAX_VARS),
  localparam int CntW  = $clog2(MAX_VARS + 1),
  localparam int PayW  = VarW + 1 + wcsp_pkg::WeightW + 1 + 1 + CntW,
  localparam int DataW = ((PayW + 7) / 8) * 8
) (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      s_axis_tready,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [DataW-1:0]          m_axis_tdata,
  input wire logic [wcsp_pkg::KindW-1:0] m_axis_tuser,
  input wire logic                      m_axis_tlast
);
  import wcsp_pkg::*;

  logic [VarW-1:0]    var_idx;
  logic               negated;
  logic [WeightW-1:0] weight;
  logic               hard;
  logic               unit_soft;

  assign var_idx   = m_axis_tdata[VarW-1:0];
  assign negated   = m_axis_tdata[VarW];
  assign weight    = m_axis_tdata[VarW+WeightW:VarW+1];
  assign hard      = m_axis_tdata[VarW+WeightW+1];
  assign unit_soft = m_axis_tdata[VarW+WeightW+2];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast))
  else $error("record changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
  else $error("input blocked with no record queued");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_LIT) |-> (var_idx == '0) && !negated)
  else $error("literal fields set on non-literal record");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(hard && unit_soft) &&
    ((m_axis_tuser == KIND_CLAUSE_END) || (!hard && !unit_soft)))
  else $error("bad clause classification");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_TOP) |-> !weight[WeightW-1])
  else $error("negative top value reported");

endmodule

bind wcnf_clause_stream_parser_top wcsp_port_checker #(
  .MAX_VARS(MAX_VARS)
) u_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
